### design/fdfb_pkg.sv
// ----------------------------------------------------------------------------
// fdfb_pkg
// Shared constants, types and digit helpers for the fuel display frame builder.
// ----------------------------------------------------------------------------
package fdfb_pkg;

    localparam int FRAME_BYTES = 17;
    localparam int POS_W       = 5;

    localparam int PRICE_W = 17;
    localparam int VOL_W   = 20;
    localparam int TOT_W   = 34;
    localparam int PROD_W  = VOL_W + PRICE_W;

    // Binary values are converted most significant bit first, a slice per stage.
    localparam int BIN_W      = 40;
    localparam int SLICE_W    = 8;
    localparam int DAB_STAGES = BIN_W / SLICE_W;

    localparam int DIGITS = 10;
    localparam int BCD_W  = 4 * DIGITS;

    localparam int PRICE_DIGITS = 5;
    localparam int VOL_DIGITS   = 6;
    localparam int TOTAL_DIGITS = 6;
    localparam int TOTZ_DIGITS  = 10;
    // The sale total is the product in thousandths: its three low digits drop.
    localparam int TOTAL_SKIP   = 3;

    localparam logic [3:0] CODE_ZERO  = 4'd0;
    localparam logic [3:0] CODE_L     = 4'd10;
    localparam logic [3:0] CODE_BLANK = 4'd15;

    localparam logic OP_PUMP      = 1'b0;
    localparam logic OP_TOTALIZER = 1'b1;

    localparam logic [POS_W-1:0] FIRST_POS = 5'd0;
    localparam logic [POS_W-1:0] LAST_POS  = 5'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] L_POS_A   = 5'd7;
    localparam logic [POS_W-1:0] L_POS_B   = 5'd8;

    // Frame byte index of each digit, lowest digit first.
    localparam logic [POS_W-1:0] PRICE_POS [PRICE_DIGITS] =
        '{5'd16, 5'd15, 5'd14, 5'd13, 5'd0};
    localparam logic [POS_W-1:0] VOL_POS [VOL_DIGITS] =
        '{5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1};
    localparam logic [POS_W-1:0] TOTAL_POS [TOTAL_DIGITS] =
        '{5'd12, 5'd11, 5'd10, 5'd9, 5'd8, 5'd7};
    localparam logic [POS_W-1:0] TOTZ_POS [TOTZ_DIGITS] =
        '{5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1, 5'd12, 5'd11, 5'd10, 5'd9};

    typedef logic [3:0] t_code;
    typedef logic [FRAME_BYTES-1:0][3:0] t_frame;
    typedef logic [DIGITS-1:0][3:0] t_digits;

    // Item travelling through the conversion pipeline.
    typedef struct packed {
        logic             op;
        logic [BIN_W-1:0] wide_bin;   // totalizer count or volume times price
        logic [BIN_W-1:0] vol_bin;
        logic [BIN_W-1:0] price_bin;
        logic [BCD_W-1:0] wide_bcd;
        logic [BCD_W-1:0] vol_bcd;
        logic [BCD_W-1:0] price_bcd;
    } t_conv;

    // One shift-and-add-3 step. The carry out of the top digit is dropped, so
    // the digits hold the value modulo ten to the number of digits.
    function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] bcd,
                                                    input logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < DIGITS; d++) begin
            if (bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    function automatic logic [BCD_W-1:0] dabble_slice(input logic [BCD_W-1:0] bcd,
                                                      input logic [SLICE_W-1:0] bits);
        logic [BCD_W-1:0] acc;
        acc = bcd;
        for (int i = SLICE_W - 1; i >= 0; i--) begin
            acc = dabble_bit(acc, bits[i]);
        end
        return acc;
    endfunction

    // Leading zero blanking over the low n digits. With keep_low set the
    // lowest digit always shows, so a zero value reads as a single 0.
    function automatic t_digits blank_field(input logic [BCD_W-1:0] bcd,
                                            input int n,
                                            input logic keep_low);
        logic    seen;
        t_digits codes;
        seen  = 1'b0;
        codes = {DIGITS{CODE_BLANK}};
        for (int i = DIGITS - 1; i >= 0; i--) begin
            if (i < n) begin
                seen = seen | (bcd[4*i +: 4] != CODE_ZERO);
                if (seen || (i == 0 && keep_low)) begin
                    codes[i] = bcd[4*i +: 4];
                end
            end
        end
        return codes;
    endfunction

endpackage

### design/fdfb_front.sv
// ----------------------------------------------------------------------------
// fdfb_front
// Price register, input stage and multiply stage of the frame builder.
// ----------------------------------------------------------------------------
module fdfb_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [fdfb_pkg::PRICE_W-1:0] i_cfg_wr_data,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic                     i_op,
    input  logic [fdfb_pkg::VOL_W-1:0]   i_volume_milli,
    input  logic [fdfb_pkg::TOT_W-1:0]   i_totalizer_milli,
    output logic                     o_valid,
    output fdfb_pkg::t_conv          o_data,
    input  logic                     i_ready
);
    import fdfb_pkg::*;

    logic [PRICE_W-1:0] r_price_centi;

    logic               r_s0_valid;
    logic               r_s0_op;
    logic [VOL_W-1:0]   r_s0_vol;
    logic [TOT_W-1:0]   r_s0_tot;

    logic               r_s1_valid;
    t_conv              r_s1_data;
    t_conv              n_s1_data;

    logic               ready0;
    logic               ready1;
    logic [PROD_W-1:0]  product;

    assign ready1 = !r_s1_valid || i_ready;
    assign ready0 = !r_s0_valid || ready1;
    assign o_busy = !ready0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_price_centi <= '0;
        end else if (i_cfg_wr_en) begin
            r_price_centi <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (ready0) begin
            r_s0_valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && ready0) begin
            r_s0_op  <= i_op;
            r_s0_vol <= i_volume_milli;
            r_s0_tot <= i_totalizer_milli;
        end
    end

    assign product = PROD_W'(r_s0_vol) * PROD_W'(r_price_centi);

    always_comb begin
        n_s1_data           = '0;
        n_s1_data.op        = r_s0_op;
        n_s1_data.wide_bin  = (r_s0_op == OP_TOTALIZER) ? BIN_W'(r_s0_tot)
                                                        : BIN_W'(product);
        n_s1_data.vol_bin   = BIN_W'(r_s0_vol);
        n_s1_data.price_bin = BIN_W'(r_price_centi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (ready1) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s0_valid && ready1) begin
            r_s1_data <= n_s1_data;
        end
    end

    assign o_valid = r_s1_valid;
    assign o_data  = r_s1_data;

endmodule

### design/fdfb_dabble.sv
// ----------------------------------------------------------------------------
// fdfb_dabble
// Pipelined binary to decimal conversion, one eight-bit slice per stage.
// ----------------------------------------------------------------------------
module fdfb_dabble (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  fdfb_pkg::t_conv i_data,
    output logic            o_ready,
    output logic            o_valid,
    output fdfb_pkg::t_conv o_data,
    input  logic            i_ready
);
    import fdfb_pkg::*;

    logic [DAB_STAGES-1:0] r_valid;
    t_conv                 r_data [DAB_STAGES];
    logic [DAB_STAGES:0]   ready;

    assign ready[DAB_STAGES] = i_ready;
    assign o_ready           = ready[0];
    assign o_valid           = r_valid[DAB_STAGES-1];
    assign o_data            = r_data[DAB_STAGES-1];

    for (genvar s = 0; s < DAB_STAGES; s++) begin : g_stage
        localparam int HI = BIN_W - 1 - s * SLICE_W;

        logic  in_valid;
        t_conv in_data;
        t_conv n_data;

        if (s == 0) begin : g_head
            assign in_valid = i_valid;
            assign in_data  = i_data;
        end else begin : g_body
            assign in_valid = r_valid[s-1];
            assign in_data  = r_data[s-1];
        end

        assign ready[s] = !r_valid[s] || ready[s+1];

        always_comb begin
            n_data           = in_data;
            n_data.wide_bcd  = dabble_slice(in_data.wide_bcd,  in_data.wide_bin[HI -: SLICE_W]);
            n_data.vol_bcd   = dabble_slice(in_data.vol_bcd,   in_data.vol_bin[HI -: SLICE_W]);
            n_data.price_bcd = dabble_slice(in_data.price_bcd, in_data.price_bin[HI -: SLICE_W]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (ready[s]) begin
                r_valid[s] <= in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (in_valid && ready[s]) begin
                r_data[s] <= n_data;
            end
        end
    end

endmodule

### design/fdfb_frame.sv
// ----------------------------------------------------------------------------
// fdfb_frame
// Leading zero blanking and placement of all digit codes into one frame.
// ----------------------------------------------------------------------------
module fdfb_frame (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  fdfb_pkg::t_conv  i_data,
    output logic             o_ready,
    output logic             o_valid,
    output fdfb_pkg::t_frame o_frame,
    input  logic             i_ready
);
    import fdfb_pkg::*;

    logic    r_valid;
    t_frame  r_frame;
    t_frame  n_frame;
    t_digits price_c;
    t_digits vol_c;
    t_digits total_c;
    t_digits totz_c;

    assign o_ready = !r_valid || i_ready;

    // The sale total sits in digits three and up of the product.
    assign price_c = blank_field(i_data.price_bcd, PRICE_DIGITS, 1'b1);
    assign vol_c   = blank_field(i_data.vol_bcd, VOL_DIGITS, 1'b1);
    assign total_c = blank_field(i_data.wide_bcd >> (4 * TOTAL_SKIP), TOTAL_DIGITS, 1'b1);
    assign totz_c  = blank_field(i_data.wide_bcd, TOTZ_DIGITS, 1'b0);

    always_comb begin
        n_frame = {FRAME_BYTES{CODE_BLANK}};
        for (int i = 0; i < PRICE_DIGITS; i++) begin
            n_frame[PRICE_POS[i]] = price_c[i];
        end
        if (i_data.op == OP_PUMP) begin
            for (int i = 0; i < TOTAL_DIGITS; i++) begin
                n_frame[TOTAL_POS[i]] = total_c[i];
            end
            for (int i = 0; i < VOL_DIGITS; i++) begin
                n_frame[VOL_POS[i]] = vol_c[i];
            end
        end else begin
            n_frame[L_POS_A] = CODE_L;
            n_frame[L_POS_B] = CODE_L;
            for (int i = 0; i < TOTZ_DIGITS; i++) begin
                n_frame[TOTZ_POS[i]] = totz_c[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_frame <= n_frame;
        end
    end

    assign o_valid = r_valid;
    assign o_frame = r_frame;

endmodule

### design/fdfb_serial.sv
// ----------------------------------------------------------------------------
// fdfb_serial
// Holds one finished frame and sends it out a byte per cycle.
// ----------------------------------------------------------------------------
module fdfb_serial (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  fdfb_pkg::t_frame           i_frame,
    output logic                       o_ready,
    output logic                       o_strobe,
    output logic [7:0]                 o_frame_byte,
    output logic [fdfb_pkg::POS_W-1:0] o_byte_position,
    output logic                       o_latch_after,
    output logic                       o_last
);
    import fdfb_pkg::*;

    logic             r_active;
    logic [POS_W-1:0] r_cnt;
    t_frame           r_frame;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic [POS_W-1:0] r_out_pos;
    logic             r_out_latch;
    logic             r_out_last;

    logic             take;
    logic [3:0]       pos_nibble;

    // A new frame may load while the last byte of the current one goes out.
    assign o_ready = !r_active || (r_cnt == LAST_POS);
    assign take    = i_valid && o_ready;

    assign pos_nibble = (r_cnt == FIRST_POS) ? 4'd0 : 4'(LAST_POS - r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_cnt       <= FIRST_POS;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_active;
            if (take) begin
                r_active <= 1'b1;
                r_cnt    <= FIRST_POS;
            end else if (r_active) begin
                if (r_cnt == LAST_POS) begin
                    r_active <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_frame <= i_frame;
        end
        if (r_active) begin
            r_out_byte  <= {r_frame[r_cnt], pos_nibble};
            r_out_pos   <= r_cnt;
            r_out_latch <= (r_cnt != FIRST_POS);
            r_out_last  <= (r_cnt == LAST_POS);
        end
    end

    assign o_strobe        = r_out_valid;
    assign o_frame_byte    = r_out_byte;
    assign o_byte_position = r_out_pos;
    assign o_latch_after   = r_out_latch;
    assign o_last          = r_out_last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_cnt <= LAST_POS))
        else $error("frame byte counter out of range");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_active && r_cnt == FIRST_POS))
        else $error("frame load did not restart the byte counter");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |=>
            (r_out_valid && r_out_pos == $past(r_out_pos) + 5'd1))
        else $error("frame bytes not sent on consecutive cycles");

endmodule

### design/fuel_display_frame_builder.sv
// ----------------------------------------------------------------------------
// fuel_display_frame_builder
// Builds the 17-byte digit frame of a six-digit dispenser display.
// ----------------------------------------------------------------------------
// The first byte of a frame comes out once the transaction has passed the
// pipeline below; the remaining 16 bytes follow on consecutive cycles. The
// one-byte-per-cycle serializer sets the throughput and takes a new frame
// during the last byte of the previous one. Reset (synchronous, active low)
// empties the pipeline and clears the unit price to zero. The receiver cannot
// stall: each byte is shown for exactly one cycle with o_strobe high.
// ----------------------------------------------------------------------------
module fuel_display_frame_builder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Unit price register, in hundredths.
    input  logic                         i_cfg_wr_en,
    input  logic [fdfb_pkg::PRICE_W-1:0] i_cfg_wr_data,
    // Command side.
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_op,
    input  logic [fdfb_pkg::VOL_W-1:0]   i_volume_milli,
    input  logic [fdfb_pkg::TOT_W-1:0]   i_totalizer_milli,
    // Frame byte side.
    output logic                         o_strobe,
    output logic [7:0]                   o_frame_byte,
    output logic [fdfb_pkg::POS_W-1:0]   o_byte_position,
    output logic                         o_latch_after,
    output logic                         o_last
);
    import fdfb_pkg::*;

    // Pipeline: an input register and a multiply register (volume times
    // price, or the totalizer count in totalizer mode), five conversion
    // stages that each shift eight binary bits into decimal digits, one stage
    // that blanks leading zeros and places every code at its frame byte, and
    // the serializer. Every stage carries a valid bit and advances whenever
    // the stage after it is free, so a transaction can enter every cycle
    // until the serializer, which drains one frame at a time, backs the
    // pipeline up. busy is the input stage's back pressure.

    logic   front_valid;
    t_conv  front_data;
    logic   front_ready;

    logic   dab_valid;
    t_conv  dab_data;
    logic   dab_ready;

    logic   frame_valid;
    t_frame frame_data;
    logic   frame_ready;

    fdfb_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_start           (start),
        .o_busy            (busy),
        .i_op              (i_op),
        .i_volume_milli    (i_volume_milli),
        .i_totalizer_milli (i_totalizer_milli),
        .o_valid           (front_valid),
        .o_data            (front_data),
        .i_ready           (front_ready)
    );

    // The sale total needs no divider: the product is converted to ten
    // decimal digits and the low three are simply dropped later on.
    fdfb_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_data  (front_data),
        .o_ready (front_ready),
        .o_valid (dab_valid),
        .o_data  (dab_data),
        .i_ready (dab_ready)
    );

    fdfb_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dab_valid),
        .i_data  (dab_data),
        .o_ready (dab_ready),
        .o_valid (frame_valid),
        .o_frame (frame_data),
        .i_ready (frame_ready)
    );

    // Each byte holds the digit code in its high nibble and the display
    // position in its low nibble; a latch pulse follows every byte but the
    // first.
    fdfb_serial u_serial (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (frame_valid),
        .i_frame         (frame_data),
        .o_ready         (frame_ready),
        .o_strobe        (o_strobe),
        .o_frame_byte    (o_frame_byte),
        .o_byte_position (o_byte_position),
        .o_latch_after   (o_latch_after),
        .o_last          (o_last)
    );

endmodule

### test/fdfb_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fdfb_frame_checker
// Watches the price register, the command side and the frame byte side of
// the fuel display frame builder, predicts the 17 bytes of every accepted
// frame and compares each byte that comes out, field by field.
// ----------------------------------------------------------------------------
module fdfb_frame_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [fdfb_pkg::PRICE_W-1:0] i_cfg_wr_data,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic                         i_op,
    input  logic [fdfb_pkg::VOL_W-1:0]   i_volume_milli,
    input  logic [fdfb_pkg::TOT_W-1:0]   i_totalizer_milli,
    input  logic                         i_strobe,
    input  logic [7:0]                   i_frame_byte,
    input  logic [fdfb_pkg::POS_W-1:0]   i_byte_position,
    input  logic                         i_latch_after,
    input  logic                         i_last,
    output int                           o_pending,
    output int                           o_fail_count
);
    import fdfb_pkg::*;

    typedef struct {
        logic [7:0]       frame_byte;
        logic [POS_W-1:0] byte_position;
        logic             latch_after;
        logic             last;
    } t_frame_byte;

    t_frame_byte        frame_bytes_due[$];
    logic [PRICE_W-1:0] price_centi;
    t_frame             codes;
    t_frame_byte        want;
    int                 fails;

    // Digit codes of a value shown in n digits, lowest digit at index 0. The
    // value wraps to its n low decimal digits first; zeros above the highest
    // nonzero digit are blank, and keep_low makes a zero value read as 0.
    function automatic t_digits decimal_codes(input longint unsigned value,
                                              input int n,
                                              input bit keep_low);
        longint unsigned modulus;
        longint unsigned v;
        t_digits         d;
        modulus = 1;
        for (int i = 0; i < n; i++) begin
            modulus = modulus * 10;
        end
        v = value % modulus;
        d = {DIGITS{CODE_BLANK}};
        for (int i = 0; i < n; i++) begin
            if (v != 0) begin
                d[i] = t_code'(v % 10);
                v    = v / 10;
            end else if (i == 0 && keep_low) begin
                d[i] = CODE_ZERO;
            end
        end
        return d;
    endfunction

    // Digit code of every frame byte for one transaction.
    function automatic t_frame frame_codes(input logic op,
                                           input logic [VOL_W-1:0] vol,
                                           input logic [TOT_W-1:0] totz,
                                           input logic [PRICE_W-1:0] price);
        t_frame          f;
        t_digits         d;
        longint unsigned sale;
        f = {FRAME_BYTES{CODE_BLANK}};
        d = decimal_codes(longint'(price), PRICE_DIGITS, 1'b1);
        for (int i = 0; i < PRICE_DIGITS; i++) begin
            f[PRICE_POS[i]] = d[i];
        end
        if (op == OP_PUMP) begin
            // Sale total in hundredths, truncated from thousandths of a liter.
            sale = (longint'(vol) * longint'(price)) / 1000;
            d = decimal_codes(sale, TOTAL_DIGITS, 1'b1);
            for (int i = 0; i < TOTAL_DIGITS; i++) begin
                f[TOTAL_POS[i]] = d[i];
            end
            d = decimal_codes(longint'(vol), VOL_DIGITS, 1'b1);
            for (int i = 0; i < VOL_DIGITS; i++) begin
                f[VOL_POS[i]] = d[i];
            end
        end else begin
            f[L_POS_A] = CODE_L;
            f[L_POS_B] = CODE_L;
            // A zero totalizer count is left fully blank.
            d = decimal_codes(longint'(totz), TOTZ_DIGITS, 1'b0);
            for (int i = 0; i < TOTZ_DIGITS; i++) begin
                f[TOTZ_POS[i]] = d[i];
            end
        end
        return f;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            price_centi <= '0;
            frame_bytes_due.delete();
        end else begin
            if (i_strobe) begin
                if (frame_bytes_due.size() == 0) begin
                    $error("frame byte %0h at position %0d with no transaction pending",
                           i_frame_byte, i_byte_position);
                    fails = fails + 1;
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (i_frame_byte !== want.frame_byte) begin
                        $error("frame_byte mismatch: expected %0h, actual %0h",
                               want.frame_byte, i_frame_byte);
                        fails = fails + 1;
                    end
                    if (i_byte_position !== want.byte_position) begin
                        $error("byte_position mismatch: expected %0d, actual %0d",
                               want.byte_position, i_byte_position);
                        fails = fails + 1;
                    end
                    if (i_latch_after !== want.latch_after) begin
                        $error("latch_after mismatch: expected %0b, actual %0b",
                               want.latch_after, i_latch_after);
                        fails = fails + 1;
                    end
                    if (i_last !== want.last) begin
                        $error("last mismatch: expected %0b, actual %0b",
                               want.last, i_last);
                        fails = fails + 1;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                price_centi <= i_cfg_wr_data;
            end
            if (i_start && !i_busy) begin
                codes = frame_codes(i_op, i_volume_milli, i_totalizer_milli, price_centi);
                for (int k = 0; k < FRAME_BYTES; k++) begin
                    want.frame_byte    = {codes[k], (k == 0) ? 4'd0 : 4'(FRAME_BYTES - 1 - k)};
                    want.byte_position = POS_W'(k);
                    want.latch_after   = (k != 0);
                    want.last          = (k == FRAME_BYTES - 1);
                    frame_bytes_due.push_back(want);
                end
            end
        end
        o_pending    <= frame_bytes_due.size();
        o_fail_count <= fails;
    end

    initial begin
        fails        = 0;
        o_pending    = 0;
        o_fail_count = 0;
    end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the fuel display frame builder: directed frames at
// the edges of every field, then random pump and totalizer frames under a
// series of unit prices, with random sender gaps.
// ----------------------------------------------------------------------------
module testbench;
    import fdfb_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [PRICE_W-1:0] i_cfg_wr_data;
    logic               start;
    logic               busy;
    logic               i_op;
    logic [VOL_W-1:0]   i_volume_milli;
    logic [TOT_W-1:0]   i_totalizer_milli;
    logic               o_strobe;
    logic [7:0]         o_frame_byte;
    logic [POS_W-1:0]   o_byte_position;
    logic               o_latch_after;
    logic               o_last;

    int pending_bytes;
    int fail_count;
    // When set, the sender never leaves a gap between transactions.
    bit steady;

    fuel_display_frame_builder uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .start             (start),
        .busy              (busy),
        .i_op              (i_op),
        .i_volume_milli    (i_volume_milli),
        .i_totalizer_milli (i_totalizer_milli),
        .o_strobe          (o_strobe),
        .o_frame_byte      (o_frame_byte),
        .o_byte_position   (o_byte_position),
        .o_latch_after     (o_latch_after),
        .o_last            (o_last)
    );

    fdfb_frame_checker frame_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_start           (start),
        .i_busy            (busy),
        .i_op              (i_op),
        .i_volume_milli    (i_volume_milli),
        .i_totalizer_milli (i_totalizer_milli),
        .i_strobe          (o_strobe),
        .i_frame_byte      (o_frame_byte),
        .i_byte_position   (o_byte_position),
        .i_latch_after     (o_latch_after),
        .i_last            (o_last),
        .o_pending         (pending_bytes),
        .o_fail_count      (fail_count)
    );

    // 12 ns clock period.
    initial begin
        i_clk = 1'b0;
    end
    always begin
        #6 i_clk = ~i_clk;
    end

    // Every task below is entered right after a rising edge and returns right
    // after one, so all inputs change on the same side of the clock.

    // Offers one transaction and returns after the edge that accepts it. The
    // start line stays high on return; a gap or a drain is what lowers it,
    // so start is never lowered and raised within one time step.
    task automatic send_frame(input logic op, input logic [VOL_W-1:0] vol,
                              input logic [TOT_W-1:0] totz);
        if (!steady && $urandom_range(0, 99) < 21) begin
            start <= 1'b0;
            // Mostly short gaps, some long enough to land anywhere in a frame.
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(5, 20)
                                              : $urandom_range(1, 3)) begin
                @(posedge i_clk);
            end
        end
        start             <= 1'b1;
        i_op              <= op;
        i_volume_milli    <= vol;
        i_totalizer_milli <= totz;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // Holds the sender back until every predicted byte has come out, then
    // lets the latency of a frame pass so that the block is surely idle.
    task automatic drain_frames();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes != 0) begin
            @(posedge i_clk);
        end
        repeat (12) begin
            @(posedge i_clk);
        end
    endtask

    // The price is only changed while no frame is in flight.
    task automatic write_price(input logic [PRICE_W-1:0] price);
        drain_frames();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= price;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [VOL_W-1:0] random_volume();
        int sel;
        sel = $urandom_range(0, 3);
        if (sel == 0) begin
            return VOL_W'($urandom_range(0, (1 << VOL_W) - 1));
        end else if (sel == 1) begin
            // Few digits, so that most volume and total digits stay blank.
            return VOL_W'($urandom_range(0, 10 ** $urandom_range(0, 5)));
        end
        return VOL_W'($urandom_range(0, 999999));
    endfunction

    function automatic logic [TOT_W-1:0] random_totalizer();
        longint unsigned wide;
        longint unsigned modulus;
        int              sel;
        sel  = $urandom_range(0, 3);
        wide = {$urandom(), $urandom()};
        if (sel == 0) begin
            return TOT_W'(wide);
        end else if (sel == 1) begin
            modulus = 1;
            repeat ($urandom_range(1, 10)) begin
                modulus = modulus * 10;
            end
            return TOT_W'(wide % modulus);
        end
        return TOT_W'(wide % 64'd10000000000);
    endfunction

    task automatic random_frames(input int count);
        for (int n = 0; n < count; n++) begin
            send_frame(logic'($urandom_range(0, 1)), random_volume(), random_totalizer());
            // Now and then the sender waits for the pipeline to run dry.
            if (!steady && $urandom_range(0, 39) == 0) begin
                drain_frames();
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = '0;
        start             = 1'b0;
        i_op              = OP_PUMP;
        i_volume_milli    = '0;
        i_totalizer_milli = '0;
        steady            = 1'b0;
        repeat (8) begin
            @(posedge i_clk);
        end
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Price left at its reset value of zero: every total reads as 0.
        send_frame(OP_PUMP, '0, '0);
        send_frame(OP_PUMP, VOL_W'(999999), '0);
        send_frame(OP_TOTALIZER, '0, '0);
        send_frame(OP_TOTALIZER, '0, TOT_W'(64'd9999999999));
        send_frame(OP_TOTALIZER, '1, '1);

        // Highest price in range; totals past six digits wrap.
        write_price(PRICE_W'(99999));
        send_frame(OP_PUMP, VOL_W'(999999), '0);
        send_frame(OP_PUMP, '1, '1);
        send_frame(OP_PUMP, VOL_W'(1), '0);
        send_frame(OP_PUMP, VOL_W'(10), '0);
        send_frame(OP_PUMP, VOL_W'(1000), '0);
        send_frame(OP_TOTALIZER, '1, TOT_W'(1));
        send_frame(OP_TOTALIZER, '0, TOT_W'(1000000));
        send_frame(OP_TOTALIZER, '0, TOT_W'(64'd1000000000));
        send_frame(OP_TOTALIZER, '0, TOT_W'(64'd1234567890));

        // All price bits set: the price wraps to its five low digits.
        write_price('1);
        send_frame(OP_PUMP, '1, '0);
        send_frame(OP_PUMP, VOL_W'(100000), '0);
        // Exactly ten to the tenth wraps to zero, which shows fully blank.
        send_frame(OP_TOTALIZER, '0, TOT_W'(64'd10000000000));

        // Smallest nonzero price: a total below one hundredth truncates to 0.
        write_price(PRICE_W'(1));
        send_frame(OP_PUMP, VOL_W'(999), '0);
        send_frame(OP_PUMP, VOL_W'(1000), '0);
        send_frame(OP_PUMP, VOL_W'(524288), TOT_W'(64'h2_0000_0000));

        // Random frames under a series of prices, extremes among them.
        random_frames(50);
        write_price(PRICE_W'(99999));
        steady = 1'b1;
        random_frames(50);
        steady = 1'b0;
        write_price('0);
        random_frames(50);
        write_price('1);
        random_frames(50);
        write_price(PRICE_W'($urandom_range(0, 99999)));
        random_frames(50);
        write_price(PRICE_W'($urandom_range(0, (1 << PRICE_W) - 1)));
        random_frames(50);
        write_price(PRICE_W'($urandom_range(1, 999)));
        random_frames(50);

        // Let the last frame come out in full, then watch for stray bytes.
        drain_frames();
        repeat (30) begin
            @(posedge i_clk);
        end
        if (fail_count == 0) begin
            $display("fuel_display_frame_builder verification clean");
        end else begin
            $display("fuel_display_frame_builder verification failed");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #6_000_000;
        $display("fuel_display_frame_builder verification failed");
        $finish;
    end

endmodule

### files.f
design/fdfb_pkg.sv
design/fdfb_front.sv
design/fdfb_dabble.sv
design/fdfb_frame.sv
design/fdfb_serial.sv
design/fuel_display_frame_builder.sv
test/fdfb_frame_checker.sv
test/testbench.sv
